@@ src/fcpt_pkg.sv @@
// ============================================================================
// fcpt_pkg
// shared types and constants of the per-function cycle profiler table
// ============================================================================
package fcpt_pkg;

    localparam int ENTRIES   = 256;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = IDX_W + 1;
    localparam int OUT_IDX_W = 8;
    localparam int ID_W      = 32;
    localparam int TS_W      = 64;
    localparam int CALLS_W   = 32;

    localparam logic MODE_ENTER  = 1'b0;
    localparam logic MODE_RETURN = 1'b1;

    typedef enum logic [1:0] {
        ST_HIT  = 2'd0,
        ST_NEW  = 2'd1,
        ST_MISS = 2'd2,
        ST_FULL = 2'd3
    } t_status;

    typedef struct packed {
        logic            mode;
        logic [ID_W-1:0] function_id;
        logic [TS_W-1:0] timestamp;
    } t_in_item;

    typedef struct packed {
        t_status              status;
        logic [OUT_IDX_W-1:0] entry_index;
        logic [CALLS_W-1:0]   call_count;
        logic [TS_W-1:0]      elapsed_cycles;
        logic [TS_W-1:0]      total_cycles_out;
        logic [TS_W-1:0]      peak_cycles_out;
        logic [TS_W-1:0]      average_cycles_out;
    } t_out_item;

    // one table entry as held in the data memory
    typedef struct packed {
        logic [CALLS_W-1:0] calls;
        logic [TS_W-1:0]    open_time;
        logic [TS_W-1:0]    total;
        logic [TS_W-1:0]    peak;
        logic [TS_W-1:0]    average;
    } t_entry;

endpackage

@@ src/function_call_profiler_table.sv @@
// ============================================================================
// function_call_profiler_table
// per-function call counter with total, peak and running average of cycles
// ============================================================================
// lookup: reads one stored key per cycle up to the fill count; a hit or a new
//   slot then reads its entry data, and a return also runs the byte-serial
//   divide-by-ten unit, 8 bits per step, before write-back
// flow: one transaction at a time, a new one is taken only while idle
// reset: synchronous, clears the fill count and control, no clearing pass
// the result strobe lasts one cycle and cannot be stalled by the receiver
module function_call_profiler_table
    import fcpt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_strobe,
    output t_out_item o_result
);

    localparam int NUM_W     = 80;
    localparam int DIV_STEPS = NUM_W / 8;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DATA_RD,
        S_DATA_WAIT,
        S_EMA,
        S_DIV,
        S_FINISH
    } t_state;

    // one byte of long division by ten, remainder stays below ten
    function automatic logic [11:0] div10_byte(input logic [3:0] rem,
                                               input logic [7:0] din);
        logic [4:0] r;
        logic [7:0] q;
        r = {1'b0, rem};
        q = '0;
        for (int k = 7; k >= 0; k--) begin
            r = {r[3:0], din[k]};
            if (r >= 5'd10) begin
                r    = r - 5'd10;
                q[k] = 1'b1;
            end
        end
        return {r[3:0], q};
    endfunction

    // memories: keys are only read below the fill count, so no reset needed
    logic [ID_W-1:0] key_mem  [ENTRIES];
    t_entry          data_mem [ENTRIES];

    t_state              r_state;
    t_in_item            r_item;
    logic [CNT_W-1:0]    r_used;
    logic [CNT_W-1:0]    r_scan;
    logic                r_rd_vld;
    logic [IDX_W-1:0]    r_rd_idx;
    logic [ID_W-1:0]     r_key_rd;
    logic [IDX_W-1:0]    r_slot;
    logic                r_new;
    t_entry              r_ent_rd;
    t_entry              r_ent;
    logic [TS_W-1:0]     r_elapsed;
    logic [NUM_W-1:0]    r_num;
    logic [NUM_W-1:0]    r_quo;
    logic [3:0]          r_rem;
    logic [DCNT_W-1:0]   r_div_cnt;
    logic                r_strobe;
    t_out_item           r_result;

    logic        issue;
    logic        match;
    logic        scan_miss;
    logic        key_we;
    logic        data_we;
    logic        n_strobe;
    t_entry      ent_cur;
    t_entry      ent_open;
    t_entry      ent_acc;
    t_entry      n_ent;
    t_out_item   miss_res;
    t_out_item   hit_res;
    logic [11:0] div_out;

    always_comb begin
        // scan pipeline: address issued this cycle, key compared next cycle
        issue     = (r_scan < r_used);
        match     = r_rd_vld && (r_key_rd == r_item.function_id);
        scan_miss = (r_state == S_SEARCH) && !issue && !match;
        key_we    = scan_miss && (r_item.mode == MODE_ENTER)
                    && (r_used != CNT_W'(ENTRIES));
        data_we   = (r_state == S_FINISH);
        // result out after write-back, or straight from a miss or a drop
        n_strobe  = data_we || (scan_miss && !key_we);
        // a freshly allocated slot reads as all zero
        ent_cur   = r_new ? '0 : r_ent_rd;
        // enter: count the call and open it
        ent_open           = ent_cur;
        ent_open.calls     = ent_cur.calls + 1'b1;
        ent_open.open_time = r_item.timestamp;
        // return: accumulate and track the longest call
        ent_acc       = r_ent;
        ent_acc.total = r_ent.total + r_elapsed;
        if (r_elapsed > r_ent.peak) begin
            ent_acc.peak = r_elapsed;
        end
        div_out   = div10_byte(r_rem, r_num[NUM_W-1 -: 8]);
        n_ent     = r_ent;
        if (r_item.mode == MODE_RETURN) begin
            // saturate when the quotient does not fit 64 bits
            n_ent.average = (|r_quo[NUM_W-1:TS_W]) ? '1 : r_quo[TS_W-1:0];
        end
        // return that misses, or enter into a full table
        miss_res        = '0;
        miss_res.status = (r_item.mode == MODE_RETURN) ? ST_MISS : ST_FULL;
        // hit or new entry, reported after the update
        hit_res.status             = r_new ? ST_NEW : ST_HIT;
        hit_res.entry_index        = OUT_IDX_W'(r_slot);
        hit_res.call_count         = n_ent.calls;
        hit_res.elapsed_cycles     = r_elapsed;
        hit_res.total_cycles_out   = n_ent.total;
        hit_res.peak_cycles_out    = n_ent.peak;
        hit_res.average_cycles_out = n_ent.average;
    end

    // key memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[r_used[IDX_W-1:0]] <= r_item.function_id;
        end
        r_key_rd <= key_mem[r_scan[IDX_W-1:0]];
    end

    // entry data memory, written back once per hit or new-entry transaction
    always_ff @(posedge i_clk) begin
        if (data_we) begin
            data_mem[r_slot] <= n_ent;
        end
        r_ent_rd <= data_mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_rd_vld <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_item   <= i_item;
                        r_scan   <= '0;
                        r_rd_vld <= 1'b0;
                        r_state  <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    r_rd_vld <= issue;
                    r_rd_idx <= r_scan[IDX_W-1:0];
                    if (issue) begin
                        r_scan <= r_scan + 1'b1;
                    end
                    if (match) begin
                        // hit on a stored identifier
                        r_slot  <= r_rd_idx;
                        r_new   <= 1'b0;
                        r_state <= S_DATA_RD;
                    end else if (!issue) begin
                        if (key_we) begin
                            // allocate the next free slot
                            r_slot  <= r_used[IDX_W-1:0];
                            r_new   <= 1'b1;
                            r_used  <= r_used + 1'b1;
                            r_state <= S_DATA_RD;
                        end else begin
                            // return that misses, or enter into a full table
                            r_result <= miss_res;
                            r_state  <= S_IDLE;
                        end
                    end
                end
                S_DATA_RD: begin
                    // data memory read of r_slot is under way
                    r_state <= S_DATA_WAIT;
                end
                S_DATA_WAIT: begin
                    if (r_item.mode == MODE_ENTER) begin
                        r_ent     <= ent_open;
                        r_elapsed <= '0;
                        r_state   <= S_FINISH;
                    end else begin
                        r_ent     <= ent_cur;
                        // wraps modulo 2^64 across a counter rollover
                        r_elapsed <= r_item.timestamp - ent_cur.open_time;
                        r_state   <= S_EMA;
                    end
                end
                S_EMA: begin
                    r_ent     <= ent_acc;
                    // numerator 9*avg + 256*elapsed, fits in 73 bits
                    r_num     <= NUM_W'({r_ent.average, 3'b000})
                                 + NUM_W'(r_ent.average)
                                 + NUM_W'({r_elapsed, 8'h00});
                    r_rem     <= '0;
                    r_div_cnt <= '0;
                    r_state   <= S_DIV;
                end
                S_DIV: begin
                    // byte-serial division by ten, most significant first
                    r_num     <= {r_num[NUM_W-9:0], 8'h00};
                    r_quo     <= {r_quo[NUM_W-9:0], div_out[7:0]};
                    r_rem     <= div_out[11:8];
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (r_div_cnt == DCNT_W'(DIV_STEPS - 1)) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    r_result <= hit_res;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

@@ src/fcpt_checker.sv @@
// ============================================================================
// fcpt_checker
// port-level checks of the profiler table, bound to the top level
// ============================================================================
module fcpt_checker
    import fcpt_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input logic      o_strobe,
    input t_out_item o_result
);

    // an accepted transaction keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    // one result per transaction, never two in a row
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe lasted more than one cycle");

    // the block is ready again while its result is shown
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("busy still high during result strobe");

    // misses and drops report index, call count, total and average as zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_result.status == ST_MISS || o_result.status == ST_FULL)
        |-> o_result.entry_index == '0 && o_result.call_count == '0
            && o_result.total_cycles_out == '0 && o_result.average_cycles_out == '0)
        else $error("miss or drop result carries nonzero fields");

    // a new entry is only made by an enter, so it shows one call and no elapsed time
    a_new_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.status == ST_NEW
        |-> o_result.call_count == CALLS_W'(1) && o_result.elapsed_cycles == '0)
        else $error("new entry result with wrong call count or elapsed time");

endmodule

bind function_call_profiler_table fcpt_checker u_fcpt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

@@ verif/tb_function_call_profiler_table.sv @@
// ============================================================================
// tb_function_call_profiler_table
// self-checking bench for the per-function cycle profiler table: a directed
// table of events, then random call/return traffic that first works on a
// small set of functions, then fills every slot and runs with the table full;
// each result is compared field by field with a typed row or the in-bench profile model
// ============================================================================
module tb_function_call_profiler_table;
    import fcpt_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;   // cycles without any transaction
    localparam int SETTLE_CYCLES  = 300;    // full-table lookup plus return path
    localparam int NUM_DIRECTED   = 20;
    localparam logic [63:0] TS_MAX = '1;

    localparam t_out_item MISS_RESULT = '{ST_MISS, 8'd0, 32'd0, 64'd0, 64'd0, 64'd0, 64'd0};

    // one row of the directed table; want is only used when has_want is set
    typedef struct packed {
        logic            mode;
        logic [31:0]     function_id;
        logic [63:0]     timestamp;
        logic            has_want;
        t_out_item       want;
    } t_stim_row;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_item  i_item  = '0;
    logic      busy;
    logic      o_strobe;
    t_out_item o_result;

    // typed expectation that travels with the item being offered
    logic      row_has_want = 1'b0;
    t_out_item row_want     = '0;

    // profile model: one slot per function, filled in order of first enter
    logic [31:0] slot_key   [ENTRIES];
    logic [63:0] slot_open  [ENTRIES];
    logic [63:0] slot_total [ENTRIES];
    logic [63:0] slot_peak  [ENTRIES];
    logic [31:0] slot_calls [ENTRIES];
    logic [63:0] slot_avg   [ENTRIES];
    int          slots_used = 0;

    t_out_item   pending_results [$];   // expected results, oldest first

    // stimulus side view of the table: which ids hold a slot, which calls are open
    logic [31:0] known_ids [$];
    bit          id_seen   [logic [31:0]];
    bit          call_open [logic [31:0]];
    logic [63:0] clock_now = 64'd0;

    t_stim_row   directed_rows [NUM_DIRECTED];

    int error_count  = 0;
    int results_seen = 0;
    int idle_cycles  = 0;
    int quiet_left   = 0;

    function_call_profiler_table dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // profile model
    // ------------------------------------------------------------------------

    // one event against the model table, returns the result it should produce
    function automatic t_out_item profile_event(t_in_item ev);
        t_out_item   res;
        int          slot;
        int          k;
        logic [63:0] spent;
        logic [75:0] blend;
        res  = '0;
        slot = -1;
        // linear search over the slots handed out so far
        for (k = 0; k < slots_used && slot < 0; k++) begin
            if (slot_key[k] == ev.function_id) begin
                slot = k;
            end
        end
        if (slot < 0) begin
            // a return for an unknown function changes nothing
            if (ev.mode == MODE_RETURN) begin
                res.status = ST_MISS;
                return res;
            end
            // no free slot: the enter is dropped
            if (slots_used >= ENTRIES) begin
                res.status = ST_FULL;
                return res;
            end
            slot             = slots_used;
            slot_key[slot]   = ev.function_id;
            slot_open[slot]  = '0;
            slot_total[slot] = '0;
            slot_peak[slot]  = '0;
            slot_calls[slot] = '0;
            slot_avg[slot]   = '0;
            slots_used++;
            res.status = ST_NEW;
        end else begin
            res.status = ST_HIT;
        end
        if (ev.mode == MODE_ENTER) begin
            slot_calls[slot] = slot_calls[slot] + 32'd1;
            slot_open[slot]  = ev.timestamp;
        end else begin
            // modulo 2^64 difference covers a wrapped cycle counter
            spent            = ev.timestamp - slot_open[slot];
            slot_total[slot] = slot_total[slot] + spent;
            if (spent > slot_peak[slot]) begin
                slot_peak[slot] = spent;
            end
            // running average in Q56.8: 0.9 old plus 0.1 new, truncated, saturating
            blend = 76'(slot_avg[slot]) * 76'd9 + (76'(spent) << 8);
            blend = blend / 76'd10;
            slot_avg[slot] = (blend[75:64] != '0) ? TS_MAX : blend[63:0];
            res.elapsed_cycles = spent;
        end
        res.entry_index        = 8'(slot);
        res.call_count         = slot_calls[slot];
        res.total_cycles_out   = slot_total[slot];
        res.peak_cycles_out    = slot_peak[slot];
        res.average_cycles_out = slot_avg[slot];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic report_error(input string msg);
        $display("ERROR: %s", msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            report_error($sformatf("result %0d %s: expected %h, got %h",
                                   results_seen, name, want, got));
        end
    endtask

    // outputs are sampled at the edge, before the dut's own updates land
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n === 1'b1) begin
            // results first: a result never belongs to an item accepted this edge
            if (o_strobe === 1'b1) begin
                if (pending_results.size() == 0) begin
                    report_error($sformatf("result %0d arrived with none expected",
                                           results_seen));
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", 64'(want.status), 64'(o_result.status));
                    check_field("entry_index", 64'(want.entry_index),
                                64'(o_result.entry_index));
                    check_field("call_count", 64'(want.call_count),
                                64'(o_result.call_count));
                    check_field("elapsed_cycles", want.elapsed_cycles,
                                o_result.elapsed_cycles);
                    check_field("total_cycles_out", want.total_cycles_out,
                                o_result.total_cycles_out);
                    check_field("peak_cycles_out", want.peak_cycles_out,
                                o_result.peak_cycles_out);
                    check_field("average_cycles_out", want.average_cycles_out,
                                o_result.average_cycles_out);
                end
                results_seen++;
            end
            // accepted transaction: the model always advances, a typed
            // expectation from the directed table takes the place of its result
            if (start === 1'b1 && busy === 1'b0) begin
                want = profile_event(i_item);
                pending_results.push_back(row_has_want ? row_want : want);
            end
            // watchdog on cycles where neither side moves anything
            if ((start === 1'b1 && busy === 1'b0) || o_strobe === 1'b1) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    function automatic logic [63:0] rand_ts();
        return {$urandom, $urandom};
    endfunction

    // random id that holds no slot yet
    function automatic logic [31:0] fresh_id();
        logic [31:0] id;
        do begin
            id = $urandom;
        end while (id_seen.exists(id));
        return id;
    endfunction

    // offer one event, hold it until taken, then idle for a random gap;
    // called right after a rising edge
    task automatic issue_event(input logic mode, input logic [31:0] id,
                               input logic [63:0] ts, input logic has_want,
                               input t_out_item want);
        int gap;
        int pick;
        start        <= 1'b1;
        i_item       <= '{mode, id, ts};
        row_has_want <= has_want;
        row_want     <= want;
        @(posedge i_clk);
        while (busy !== 1'b0) begin
            @(posedge i_clk);
        end
        // keep the stimulus view of the table in step with the dut
        if (mode == MODE_ENTER && !id_seen.exists(id) && known_ids.size() < ENTRIES) begin
            known_ids.push_back(id);
            id_seen[id] = 1'b1;
        end
        if (id_seen.exists(id)) begin
            call_open[id] = (mode == MODE_ENTER);
        end
        // mostly back to back or short gaps, a few long ones, some back-to-back runs
        if (quiet_left > 0) begin
            quiet_left--;
            gap = 0;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                gap = 0;
            end else if (pick < 85) begin
                gap = $urandom_range(1, 4);
            end else if (pick < 97) begin
                gap = $urandom_range(5, 40);
            end else begin
                gap = $urandom_range(41, 300);
            end
            if (pick == 0) begin
                quiet_left = $urandom_range(20, 80);
            end
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold the sender off until every expected result has come back
    task automatic wait_for_results();
        start <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_results.size() != 0);
    endtask

    // mostly well-formed enter/return pairs on functions already in the
    // table; the rest is new functions, returns that miss and out-of-order
    // events with arbitrary timestamps; new functions are only offered while
    // the table holds fewer than grow_limit, or when it is full
    task automatic random_event(input int grow_limit);
        logic [31:0] id;
        int          pick;
        pick      = $urandom_range(0, 99);
        clock_now = clock_now + 64'($urandom_range(1, 2000));
        if ($urandom_range(0, 49) == 0) begin
            clock_now = rand_ts();   // counter jump, can wrap inside a call
        end
        if (known_ids.size() == 0 || (pick >= 75 && pick < 85 &&
                (known_ids.size() < grow_limit || known_ids.size() == ENTRIES))) begin
            issue_event(MODE_ENTER, fresh_id(), clock_now, 1'b0, '0);
        end else if (pick < 75) begin
            id = known_ids[$urandom_range(0, known_ids.size() - 1)];
            issue_event(call_open[id] ? MODE_RETURN : MODE_ENTER, id, clock_now,
                        1'b0, '0);
        end else if (pick < 93) begin
            issue_event(MODE_RETURN, fresh_id(), rand_ts(), 1'b0, '0);
        end else begin
            id = known_ids[$urandom_range(0, known_ids.size() - 1)];
            issue_event(($urandom_range(0, 1) == 0) ? MODE_ENTER : MODE_RETURN, id,
                        rand_ts(), 1'b0, '0);
        end
    endtask

    initial begin
        int row;
        int n;
        // directed table: typed results only where they follow at a glance
        directed_rows = '{
            // return before any enter: empty table misses
            '{MODE_RETURN, 32'h0000_1234, 64'd0, 1'b1, MISS_RESULT},
            // lowest and highest ids, lowest and highest timestamps
            '{MODE_ENTER, 32'h0000_0000, 64'd0, 1'b1,
              '{ST_NEW, 8'd0, 32'd1, 64'd0, 64'd0, 64'd0, 64'd0}},
            '{MODE_ENTER, 32'hFFFF_FFFF, TS_MAX, 1'b1,
              '{ST_NEW, 8'd1, 32'd1, 64'd0, 64'd0, 64'd0, 64'd0}},
            // plain return: average is 256*100/10
            '{MODE_RETURN, 32'h0000_0000, 64'd100, 1'b1,
              '{ST_HIT, 8'd0, 32'd1, 64'd100, 64'd100, 64'd100, 64'd2560}},
            // counter wrapped during the call: elapsed is 16
            '{MODE_RETURN, 32'hFFFF_FFFF, 64'd15, 1'b1,
              '{ST_HIT, 8'd1, 32'd1, 64'd16, 64'd16, 64'd16, 64'd409}},
            '{MODE_RETURN, 32'hFFFF_FFFE, 64'h8000_0000_0000_0000, 1'b1, MISS_RESULT},
            // zero-length call
            '{MODE_ENTER, 32'h0000_0000, 64'd1000, 1'b0, '0},
            '{MODE_RETURN, 32'h0000_0000, 64'd1000, 1'b0, '0},
            // longest possible call: average saturates
            '{MODE_ENTER, 32'h8000_0000, 64'd0, 1'b1,
              '{ST_NEW, 8'd2, 32'd1, 64'd0, 64'd0, 64'd0, 64'd0}},
            '{MODE_RETURN, 32'h8000_0000, TS_MAX, 1'b1,
              '{ST_HIT, 8'd2, 32'd1, TS_MAX, TS_MAX, TS_MAX, TS_MAX}},
            // another longest call: total wraps
            '{MODE_ENTER, 32'h8000_0000, 64'd0, 1'b0, '0},
            '{MODE_RETURN, 32'h8000_0000, TS_MAX, 1'b0, '0},
            // alternating bit patterns, wrapped elapsed
            '{MODE_ENTER, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
            '{MODE_RETURN, 32'h5555_5555, 64'h5555_5555_5555_5555, 1'b0, '0},
            // nested calls
            '{MODE_ENTER, 32'h0000_0000, 64'd2000, 1'b0, '0},
            '{MODE_ENTER, 32'hFFFF_FFFF, 64'd2100, 1'b0, '0},
            '{MODE_RETURN, 32'hFFFF_FFFF, 64'd2600, 1'b0, '0},
            '{MODE_RETURN, 32'h0000_0000, 64'd9000, 1'b0, '0},
            // second return with no new enter reuses the old open time
            '{MODE_RETURN, 32'h0000_0000, 64'd9500, 1'b0, '0},
            '{MODE_ENTER, 32'hAAAA_AAAA, 64'h5555_5555_5555_5555, 1'b1,
              '{ST_NEW, 8'd4, 32'd1, 64'd0, 64'd0, 64'd0, 64'd0}}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (row = 0; row < NUM_DIRECTED; row++) begin
            issue_event(directed_rows[row].mode, directed_rows[row].function_id,
                        directed_rows[row].timestamp, directed_rows[row].has_want,
                        directed_rows[row].want);
        end
        wait_for_results();
        clock_now = 64'd10_000;

        // small working set: short searches, many calls per function
        for (n = 0; n < 450; n++) begin
            random_event(24);
        end
        wait_for_results();

        // fill every slot, with some traffic on the functions already known
        while (known_ids.size() < ENTRIES) begin
            if ($urandom_range(0, 3) == 0) begin
                random_event(ENTRIES);
            end else begin
                clock_now = clock_now + 64'($urandom_range(1, 2000));
                issue_event(MODE_ENTER, fresh_id(), clock_now, 1'b0, '0);
            end
        end
        wait_for_results();

        // full table: deep searches, dropped enters for new functions
        for (n = 0; n < 600; n++) begin
            random_event(ENTRIES);
        end
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ function_call_profiler_table.f @@
src/fcpt_pkg.sv
src/function_call_profiler_table.sv
src/fcpt_checker.sv
verif/tb_function_call_profiler_table.sv
